FILE: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU page replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned NUM_FRAMES = 16;
  localparam int unsigned IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned USE_W      = 16;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned FAULT_W    = 32;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned CFG_RESET  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } lfu_state_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INC,
    WR_LOAD
  } lfu_wr_op_e;

  typedef struct packed {
    lfu_wr_op_e           op;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_W-1:0]    page;
    logic [STAMP_W-1:0]   stamp;
  } lfu_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_W-1:0]    page;
    logic [USE_W-1:0]     count;
    logic [STAMP_W-1:0]   stamp;
  } lfu_entry_t;

endpackage

FILE: src/lfu_frame_store.sv
// ----------------------------------------------------------------------------
// lfu_frame_store
// Frame table: resident page, valid bit, use count and load stamp per frame.
// One read index and one write command per cycle.
// ----------------------------------------------------------------------------
module lfu_frame_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lfu_pkg::IDX_W-1:0]   rd_idx_i,
  output lfu_pkg::lfu_entry_t         rd_o,
  input  lfu_pkg::lfu_wr_t            wr_i
);
  import lfu_pkg::*;

  logic [PAGE_W-1:0]  page_q  [NUM_FRAMES];
  logic [USE_W-1:0]   count_q [NUM_FRAMES];
  logic [STAMP_W-1:0] stamp_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q;

  logic [USE_W-1:0] wr_count;

  assign wr_count = count_q[wr_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.op == WR_LOAD) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (wr_i.op)
      WR_LOAD: begin
        page_q[wr_i.idx]  <= wr_i.page;
        count_q[wr_i.idx] <= USE_W'(1);
        stamp_q[wr_i.idx] <= wr_i.stamp;
      end
      WR_INC: begin
        if (wr_count != '1) begin
          count_q[wr_i.idx] <= wr_count + USE_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.page  = page_q[rd_idx_i];
    rd_o.count = valid_q[rd_idx_i] ? count_q[rd_idx_i] : '0;
    rd_o.stamp = stamp_q[rd_idx_i];
  end

endmodule

FILE: src/lfu_seq.sv
// ----------------------------------------------------------------------------
// lfu_seq
// Sequencer: serial lookup, serial victim scan with one shared compare,
// table update, counters and the output register.
// ----------------------------------------------------------------------------
module lfu_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfu_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lfu_pkg::PAGE_W-1:0]    page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [lfu_pkg::SLOT_W-1:0]    frame_slot_o,
  output logic                          evicted_valid_o,
  output logic [lfu_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic [lfu_pkg::FAULT_W-1:0]   fault_total_o,
  output logic [lfu_pkg::IDX_W-1:0]     rd_idx_o,
  input  lfu_pkg::lfu_entry_t           rd_i,
  output lfu_pkg::lfu_wr_t              wr_o
);
  import lfu_pkg::*;

  lfu_state_e           state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PAGE_W-1:0]    page_q, page_d;
  logic                 hit_q, hit_d;
  logic                 ev_valid_q, ev_valid_d;
  logic [PAGE_W-1:0]    ev_page_q, ev_page_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [USE_W-1:0]     best_cnt_q, best_cnt_d;
  logic [STAMP_W-1:0]   best_stamp_q, best_stamp_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [STAMP_W-1:0]   ref_q, ref_d;
  logic [FAULT_W-1:0]   fault_q, fault_d;
  logic [CFG_W-1:0]     cfg_q, cfg_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic                 out_ev_valid_q, out_ev_valid_d;
  logic [PAGE_W-1:0]    out_ev_page_q, out_ev_page_d;
  logic [FAULT_W-1:0]   out_fault_q, out_fault_d;

  logic [CNT_W-1:0]     n_act;
  logic [IDX_W-1:0]     last_idx;
  logic                 better;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_q) > NUM_FRAMES) begin
      n_act = CNT_W'(NUM_FRAMES);
    end else begin
      n_act = CNT_W'(cfg_q);
    end
  end

  assign last_idx = IDX_W'(n_act - CNT_W'(1));

  assign better = (idx_q == '0) || (rd_i.count < best_cnt_q) ||
                  ((rd_i.count == best_cnt_q) && (rd_i.stamp < best_stamp_q));

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign rd_idx_o    = idx_q;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    page_d         = page_q;
    hit_d          = hit_q;
    ev_valid_d     = ev_valid_q;
    ev_page_d      = ev_page_q;
    best_idx_d     = best_idx_q;
    best_cnt_d     = best_cnt_q;
    best_stamp_d   = best_stamp_q;
    fill_d         = fill_q;
    ref_d          = ref_q;
    fault_d        = fault_q;
    cfg_d          = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cfg_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_hit_d      = out_hit_q;
    out_slot_d     = out_slot_q;
    out_ev_valid_d = out_ev_valid_q;
    out_ev_page_d  = out_ev_page_q;
    out_fault_d    = out_fault_q;
    wr_o.op        = WR_NONE;
    wr_o.idx       = idx_q;
    wr_o.page      = page_q;
    wr_o.stamp     = ref_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          page_d     = page_number_i;
          idx_d      = '0;
          hit_d      = 1'b0;
          ev_valid_d = 1'b0;
          ev_page_d  = '0;
          if (ref_q != '1) begin
            ref_d = ref_q + STAMP_W'(1);
          end
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (rd_i.valid && (rd_i.page == page_q)) begin
          hit_d   = 1'b1;
          state_d = ST_UPDATE;
        end else if (idx_q == last_idx) begin
          if (fill_q < n_act) begin
            idx_d   = IDX_W'(fill_q);
            state_d = ST_UPDATE;
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        if (better) begin
          best_idx_d   = idx_q;
          best_cnt_d   = rd_i.count;
          best_stamp_d = rd_i.stamp;
          ev_valid_d   = rd_i.valid;
          ev_page_d    = rd_i.page;
        end
        if (idx_q == last_idx) begin
          idx_d   = better ? idx_q : best_idx_q;
          state_d = ST_UPDATE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_UPDATE: begin
        if (hit_q) begin
          wr_o.op = WR_INC;
        end else begin
          wr_o.op = WR_LOAD;
          if (fault_q != '1) begin
            fault_d = fault_q + FAULT_W'(1);
          end
          if (fill_q < n_act) begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_hit_d      = hit_q;
          out_slot_d     = SLOT_W'(idx_q);
          out_ev_valid_d = ev_valid_q;
          out_ev_page_d  = ev_valid_q ? ev_page_q : '0;
          out_fault_d    = fault_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ref_q       <= '0;
      fault_q     <= '0;
      cfg_q       <= CFG_W'(CFG_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ref_q       <= ref_d;
      fault_q     <= fault_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    page_q         <= page_d;
    hit_q          <= hit_d;
    ev_valid_q     <= ev_valid_d;
    ev_page_q      <= ev_page_d;
    best_idx_q     <= best_idx_d;
    best_cnt_q     <= best_cnt_d;
    best_stamp_q   <= best_stamp_d;
    out_hit_q      <= out_hit_d;
    out_slot_q     <= out_slot_d;
    out_ev_valid_q <= out_ev_valid_d;
    out_ev_page_q  <= out_ev_page_d;
    out_fault_q    <= out_fault_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign frame_slot_o    = out_slot_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = out_ev_page_q;
  assign fault_total_o   = out_fault_q;

  // result parked in FINISH until the output register frees up
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && out_valid_q && !out_ready_i |=> (state_q == ST_FINISH))
    else $error("finish state left while output register busy");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= NUM_FRAMES)
    else $error("fill pointer beyond frame count");

  a_lookup_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) || (state_q == ST_SCAN) |-> idx_q <= last_idx)
    else $error("scan index beyond active frames");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && !hit_q |=> fault_q != '0)
    else $error("miss did not count a fault");

endmodule

FILE: src/lfu_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit
// LFU page replacement with first-loaded tie-break.
//
// Channels: cfg (valid/ready, always ready) writes frames_in_use (0 acts as 1,
// above the frame count acts as the frame count); write only while idle.
// in (valid/ready) transfers one page reference; out (valid/ready) transfers
// one result per reference: hit, frame slot, evicted page and fault total.
// A reference is looked up one frame per cycle, up to the hit or through all
// n active frames on a miss. A miss with all n frames full adds a victim scan,
// one frame per cycle through a single count/stamp compare. Acceptance comes
// first; the table update and then the load of the output register follow the
// lookup or scan, and the load waits while the earlier result is not yet taken.
// The frame table has one read port, which is why frames go one at a time.
// in_ready is high only while no reference is in work. A finished result
// waits in the output register; the next reference is accepted meanwhile,
// but its result stalls until the receiver takes the earlier one.
// Reset empties all frames, clears the counters and sets frames_in_use to 16.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfu_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lfu_pkg::PAGE_W-1:0]    page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [lfu_pkg::SLOT_W-1:0]    frame_slot_o,
  output logic                          evicted_valid_o,
  output logic [lfu_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic [lfu_pkg::FAULT_W-1:0]   fault_total_o
);
  import lfu_pkg::*;

  logic [IDX_W-1:0] rd_idx;
  lfu_entry_t       rd_entry;
  lfu_wr_t          wr_cmd;

  lfu_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o),
    .rd_idx_o        (rd_idx),
    .rd_i            (rd_entry),
    .wr_o            (wr_cmd)
  );

  lfu_frame_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_entry),
    .wr_i     (wr_cmd)
  );

endmodule

FILE: tb/tb_lfu_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// tb_lfu_page_replacement_unit
// Self-checking bench for the LFU page replacement unit. A directed plan covers
// the field extremes, frame-count clamping, shrink and regrow with duplicate
// residents and repeated hits on a single frame. Random phases with
// working-set locality follow. Results are compared against an in-bench frame
// table model, but typed plan rows are compared against their own expected result.
// ----------------------------------------------------------------------------
module tb_lfu_page_replacement_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_FRAMES + 8;
  localparam int unsigned RAND_PHASES  = 15;
  localparam int unsigned PHASE_REFS   = 90;
  localparam int unsigned WS_MAX       = 24;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_W-1:0]    ev_page;
    logic [FAULT_W-1:0]   faults;
  } lfu_result_t;

  typedef enum logic {ROW_CFG, ROW_REF} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [PAGE_W-1:0]    value;
    logic [31:0]          reps;
    logic [PAGE_W-1:0]    stride;
    logic                 typed;
    lfu_result_t          want;
  } stim_row_t;

  // page = value + rep * stride; typed rows carry their own expected result
  localparam stim_row_t PLAN [24] = '{
    '{ROW_REF, 16'h0000, 32'd1,     16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_REF, 16'hFFFF, 32'd1,     16'h0000, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REF, 16'h0000, 32'd1,     16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REF, 16'h0100, 32'd14,    16'h0001, 1'b0, '0},
    '{ROW_REF, 16'hFFFF, 32'd1,     16'h0000, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd16}},
    '{ROW_REF, 16'hAAAA, 32'd1,     16'h0000, 1'b1, '{1'b0, 4'd2, 1'b1, 16'h0100, 32'd17}},
    '{ROW_CFG, 16'd0,    32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h5555, 32'd1,     16'h0000, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd18}},
    '{ROW_REF, 16'h5555, 32'd1,     16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd18}},
    '{ROW_CFG, 16'd2,    32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'hAAAA, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_CFG, 16'd31,   32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'hAAAA, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'hFFFF, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_CFG, 16'd1,    32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h0F0F, 32'd16,    16'h0000, 1'b0, '0},
    '{ROW_CFG, 16'd2,    32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h3C3C, 32'd3,     16'h0101, 1'b0, '0},
    '{ROW_CFG, 16'd16,   32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h7FFF, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h8000, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h0F0F, 32'd1,     16'h0000, 1'b0, '0},
    '{ROW_CFG, 16'd17,   32'd1,     16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h1357, 32'd4,     16'h2468, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PAGE_W-1:0]    page_number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [SLOT_W-1:0]    frame_slot_o;
  logic                 evicted_valid_o;
  logic [PAGE_W-1:0]    evicted_page_o;
  logic [FAULT_W-1:0]   fault_total_o;

  lfu_page_replacement_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // frame table model
  logic [PAGE_W-1:0]    tbl_page  [NUM_FRAMES];
  bit                   tbl_valid [NUM_FRAMES];
  logic [USE_W-1:0]     tbl_uses  [NUM_FRAMES];
  logic [STAMP_W-1:0]   tbl_stamp [NUM_FRAMES];
  int unsigned          fill_ptr;
  logic [STAMP_W-1:0]   ref_count;
  logic [FAULT_W-1:0]   fault_count;
  logic [CFG_W-1:0]     frames_cfg;

  lfu_result_t          awaited_results [$];
  int unsigned          mismatches;
  int unsigned          idle_cycles;
  int unsigned          burst_left;

  bit                   hold_request;
  bit                   hold_done;
  int unsigned          hold_left;
  int unsigned          rx_cycle;
  int unsigned          rx_mode;

  lfu_result_t          oldest_result;
  lfu_result_t          seen_result;

  function automatic lfu_result_t predict_reference(logic [PAGE_W-1:0] pg);
    lfu_result_t res;
    int unsigned n;
    int unsigned slot;
    bit found;
    res = '0;
    found = 1'b0;
    slot = 0;
    n = (frames_cfg == '0) ? 1 :
        ((32'(frames_cfg) > NUM_FRAMES) ? NUM_FRAMES : 32'(frames_cfg));
    if (ref_count != '1) ref_count++;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && tbl_valid[i] && tbl_page[i] == pg) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (tbl_uses[slot] != '1) tbl_uses[slot]++;
    end else begin
      if (fill_ptr < n) begin
        slot = fill_ptr;
        fill_ptr++;
      end else begin
        // lowest count, then earliest load, then lowest index
        for (int unsigned i = 1; i < n; i++) begin
          if (tbl_uses[i] < tbl_uses[slot] ||
              (tbl_uses[i] == tbl_uses[slot] && tbl_stamp[i] < tbl_stamp[slot]))
            slot = i;
        end
        if (tbl_valid[slot]) begin
          res.ev_valid = 1'b1;
          res.ev_page = tbl_page[slot];
        end
      end
      tbl_page[slot]  = pg;
      tbl_valid[slot] = 1'b1;
      tbl_uses[slot]  = USE_W'(1);
      tbl_stamp[slot] = ref_count;
      if (fault_count != '1) fault_count++;
    end
    res.slot = slot[SLOT_W-1:0];
    res.faults = fault_count;
    return res;
  endfunction

  task automatic send_page(input logic [PAGE_W-1:0] pg, input bit use_fixed,
                           input lfu_result_t fixed_res);
    bit taken;
    lfu_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    page_number_i <= pg;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    res = predict_reference(pg);
    awaited_results.push_back(use_fixed ? fixed_res : res);
  endtask

  // frame count changes only once the unit has drained
  task automatic write_frames(input logic [CFG_W-1:0] frames);
    bit taken;
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= frames;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    frames_cfg = frames;
  endtask

  task automatic note_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // result checker, sampled mid-cycle ahead of the transfer edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result = '{hit_o, frame_slot_o, evicted_valid_o, evicted_page_o, fault_total_o};
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, seen_result);
      end else begin
        oldest_result = awaited_results.pop_front();
        note_field("hit", 32'(oldest_result.hit), 32'(seen_result.hit));
        note_field("frame_slot", 32'(oldest_result.slot), 32'(seen_result.slot));
        note_field("evicted_valid", 32'(oldest_result.ev_valid),
                   32'(seen_result.ev_valid));
        note_field("evicted_page", 32'(oldest_result.ev_page),
                   32'(seen_result.ev_page));
        note_field("fault_total", oldest_result.faults, seen_result.faults);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("lfu_page_replacement_unit verification failed");
        $finish;
      end
    end
  end

  // receiver: stall mode is redrawn at random from four modes, plus one long hold-off
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_request && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (rx_cycle[1:0] == 2'b00);
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    logic [PAGE_W-1:0] ws [WS_MAX];
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] last_pg;
    logic [CFG_W-1:0] fcfg;
    int unsigned ws_size;
    int unsigned pick;
    foreach (tbl_valid[f]) begin
      tbl_valid[f] = 1'b0;
      tbl_uses[f] = '0;
    end
    fill_ptr = 0;
    ref_count = '0;
    fault_count = '0;
    frames_cfg = CFG_W'(CFG_RESET);
    last_pg = '0;
    foreach (ws[w]) ws[w] = PAGE_W'($urandom_range(0, 16'hFFFF));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_CFG) begin
        write_frames(PLAN[r].value[CFG_W-1:0]);
      end else begin
        for (int unsigned k = 0; k < PLAN[r].reps; k++)
          send_page(PAGE_W'(PLAN[r].value + k * PLAN[r].stride), PLAN[r].typed,
                    PLAN[r].want);
      end
    end

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: fcfg = CFG_W'(0);
          1: fcfg = CFG_W'(1);
          2: fcfg = CFG_W'(16);
          default: fcfg = CFG_W'(31);
        endcase
      end else begin
        fcfg = CFG_W'($urandom_range(0, 31));
      end
      write_frames(fcfg);
      if (ph == 3) hold_request = 1'b1;
      // keeping the working set across phases lets regrown frames hit again
      if ($urandom_range(0, 1) == 0)
        foreach (ws[w]) ws[w] = PAGE_W'($urandom_range(0, 16'hFFFF));
      ws_size = $urandom_range(1, WS_MAX);
      for (int unsigned k = 0; k < PHASE_REFS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) pg = ws[$urandom_range(0, ws_size - 1)];
        else if (pick < 90) pg = PAGE_W'($urandom_range(0, 16'hFFFF));
        else if (pick < 95) pg = pick[0] ? '1 : '0;
        else pg = last_pg;
        last_pg = pg;
        send_page(pg, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("lfu_page_replacement_unit verification clean");
    else
      $display("lfu_page_replacement_unit verification failed");
    $finish;
  end

endmodule
